@@ rtl/core/rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants for the RGB to HSV converter
// Pixel payload structs, divider lane struct and fixed-point widths.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int HUE_BITS      = 12;
  localparam int SAT_FRAC_BITS = 12;
  localparam int SAT_BITS      = SAT_FRAC_BITS + 1;

  // remainder holds up to twice 6 * delta
  localparam int DIV_W = CHANNEL_BITS + 4;

  // one cell per quotient bit of the longer division
  localparam int NUM_CELLS = ((HUE_BITS > SAT_FRAC_BITS) ? HUE_BITS : SAT_FRAC_BITS) + 1;
  localparam int HUE_FIRST = NUM_CELLS - HUE_BITS - 1;
  localparam int SAT_FIRST = NUM_CELLS - SAT_BITS;

  localparam logic [SAT_BITS-1:0] SAT_ONE = SAT_BITS'(1) << SAT_FRAC_BITS;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
    logic [CHANNEL_BITS-1:0] alpha_in;
  } in_pix_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue_out;
    logic [SAT_BITS-1:0]     saturation_out;
    logic [CHANNEL_BITS-1:0] value_out;
    logic [CHANNEL_BITS-1:0] alpha_out;
  } out_pix_t;

  // data handed from cell to cell
  typedef struct packed {
    logic [DIV_W-1:0]        hue_rem;
    logic [DIV_W-1:0]        hue_div;
    logic [HUE_BITS-1:0]     hue_q;
    logic [DIV_W-1:0]        sat_rem;
    logic [DIV_W-1:0]        sat_div;
    logic [SAT_BITS-1:0]     sat_q;
    logic [CHANNEL_BITS-1:0] value;
    logic [CHANNEL_BITS-1:0] alpha;
  } lane_t;

endpackage

@@ rtl/core/rhc_prep.sv @@
// ----------------------------------------------------------------------------
// rhc_prep: front stage of the converter
// Finds max, min and delta, forms the hue numerator and divisors.
// ----------------------------------------------------------------------------
module rhc_prep import rhc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  output logic    up_ready,
  input  in_pix_t up_pix,
  output logic    dn_valid,
  input  logic    dn_ready,
  output lane_t   dn_lane
);

  logic                    valid_r;
  lane_t                   lane_r;
  lane_t                   lane_nxt;
  logic [CHANNEL_BITS-1:0] mx;
  logic [CHANNEL_BITS-1:0] mn;
  logic [CHANNEL_BITS-1:0] delta;
  logic [DIV_W-1:0]        span;
  logic signed [DIV_W-1:0] r_s;
  logic signed [DIV_W-1:0] g_s;
  logic signed [DIV_W-1:0] b_s;
  logic signed [DIV_W-1:0] d_s;
  logic signed [DIV_W-1:0] num;

  always_comb begin
    mx = up_pix.red_in;
    mn = up_pix.red_in;
    if (up_pix.green_in > mx) mx = up_pix.green_in;
    if (up_pix.blue_in > mx) mx = up_pix.blue_in;
    if (up_pix.green_in < mn) mn = up_pix.green_in;
    if (up_pix.blue_in < mn) mn = up_pix.blue_in;
    delta = mx - mn;
    span  = (DIV_W'(delta) << 2) + (DIV_W'(delta) << 1);

    r_s = $signed(DIV_W'(up_pix.red_in));
    g_s = $signed(DIV_W'(up_pix.green_in));
    b_s = $signed(DIV_W'(up_pix.blue_in));
    d_s = $signed(DIV_W'(delta));

    // sector priority: red, then green, then blue
    if (up_pix.red_in == mx) begin
      num = g_s - b_s;
    end else if (up_pix.green_in == mx) begin
      num = (d_s <<< 1) + b_s - r_s;
    end else begin
      num = (d_s <<< 2) + r_s - g_s;
    end
    if (num[DIV_W-1]) begin
      num = num + $signed(span);
    end

    lane_nxt       = '0;
    lane_nxt.value = mx;
    lane_nxt.alpha = up_pix.alpha_in;
    // grey pixel: zero over one keeps every quotient bit at zero
    if (delta == '0) begin
      lane_nxt.hue_rem = '0;
      lane_nxt.hue_div = DIV_W'(1);
    end else begin
      lane_nxt.hue_rem = $unsigned(num);
      lane_nxt.hue_div = span;
    end
    lane_nxt.sat_rem = DIV_W'(delta);
    lane_nxt.sat_div = (mx == '0) ? DIV_W'(1) : DIV_W'(mx);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      lane_r <= lane_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_lane  = lane_r;

endmodule

@@ rtl/core/rhc_div_cell.sv @@
// ----------------------------------------------------------------------------
// rhc_div_cell: one restoring-division step for the hue and saturation lanes
// Compares, subtracts, shifts the remainder and appends one quotient bit.
// ----------------------------------------------------------------------------
module rhc_div_cell import rhc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  hue_en,
  input  logic  sat_en,
  input  logic  up_valid,
  output logic  up_ready,
  input  lane_t up_lane,
  output logic  dn_valid,
  input  logic  dn_ready,
  output lane_t dn_lane
);

  logic             valid_r;
  lane_t            lane_r;
  lane_t            lane_nxt;
  logic             hue_ge;
  logic             sat_ge;
  logic [DIV_W-1:0] hue_sub;
  logic [DIV_W-1:0] sat_sub;

  always_comb begin
    lane_nxt = up_lane;
    hue_ge   = up_lane.hue_rem >= up_lane.hue_div;
    sat_ge   = up_lane.sat_rem >= up_lane.sat_div;
    hue_sub  = hue_ge ? (up_lane.hue_rem - up_lane.hue_div) : up_lane.hue_rem;
    sat_sub  = sat_ge ? (up_lane.sat_rem - up_lane.sat_div) : up_lane.sat_rem;
    // an idle lane passes its remainder untouched until its first step
    if (hue_en) begin
      lane_nxt.hue_rem = hue_sub << 1;
      lane_nxt.hue_q   = {up_lane.hue_q[HUE_BITS-2:0], hue_ge};
    end
    if (sat_en) begin
      lane_nxt.sat_rem = sat_sub << 1;
      lane_nxt.sat_q   = {up_lane.sat_q[SAT_BITS-2:0], sat_ge};
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      lane_r <= lane_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_lane  = lane_r;

endmodule

@@ rtl/core/rgb_to_hsv_converter.sv @@
// Pipeline: each stage is registered between input transfer and out_valid:
//   one front stage, then one cell per quotient bit of the division.
// Throughput: one pixel per cycle; each stage holds its item only while the next is full.
// Reset: rst_n low clears every stage valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: RGBA to HSV plus alpha pixel converter
// Front stage feeds a row of division cells that produce hue and saturation.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter import rhc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_pix_t  in_pix,
  output logic     out_valid,
  input  logic     out_ready,
  output out_pix_t out_pix
);

  logic  prep_valid;
  lane_t prep_lane;
  logic  cell_valid [NUM_CELLS];
  logic  cell_ready [NUM_CELLS];
  lane_t cell_lane  [NUM_CELLS];

  rhc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_pix   (in_pix),
    .dn_valid (prep_valid),
    .dn_ready (cell_ready[0]),
    .dn_lane  (prep_lane)
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic  up_valid;
    lane_t up_lane;
    logic  dn_ready;

    if (i == 0) begin : g_first
      assign up_valid = prep_valid;
      assign up_lane  = prep_lane;
    end else begin : g_next
      assign up_valid = cell_valid[i-1];
      assign up_lane  = cell_lane[i-1];
    end

    if (i == NUM_CELLS - 1) begin : g_last
      assign dn_ready = out_ready;
    end else begin : g_mid
      assign dn_ready = cell_ready[i+1];
    end

    rhc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .hue_en   (1'(i >= HUE_FIRST)),
      .sat_en   (1'(i >= SAT_FIRST)),
      .up_valid (up_valid),
      .up_ready (cell_ready[i]),
      .up_lane  (up_lane),
      .dn_valid (cell_valid[i]),
      .dn_ready (dn_ready),
      .dn_lane  (cell_lane[i])
    );
  end

  assign out_valid              = cell_valid[NUM_CELLS-1];
  assign out_pix.hue_out        = cell_lane[NUM_CELLS-1].hue_q;
  assign out_pix.saturation_out = cell_lane[NUM_CELLS-1].sat_q;
  assign out_pix.value_out      = cell_lane[NUM_CELLS-1].value;
  assign out_pix.alpha_out      = cell_lane[NUM_CELLS-1].alpha;

`ifndef ASSERT_OFF
  // saturation never exceeds 1.0
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pix.saturation_out <= SAT_ONE)
    else $error("saturation above full scale");

  // black pixel gives zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pix.value_out == '0 |->
      out_pix.saturation_out == '0 && out_pix.hue_out == '0)
    else $error("black pixel with nonzero hue or saturation");

  // zero saturation means a grey pixel, so hue must be zero
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pix.saturation_out == '0 |-> out_pix.hue_out == '0)
    else $error("grey pixel with nonzero hue");

  // the input side only stalls when the row is backed up from the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");
`endif

endmodule

@@ verif/tb_rgb_to_hsv_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_converter: self-checking bench for the RGB to HSV converter
// Directed corner pixels, then shaped random pixels, with random idle gaps on
// the input and random stalls on the output; every result is checked against
// an in-bench HSV calculation in transfer order.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter;
  import rhc_pkg::*;

  localparam int NUM_RANDOM  = 1450;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_pix_t  in_pix;
  logic     out_valid;
  logic     out_ready;
  out_pix_t out_pix;

  in_pix_t  pixel_queue[$];
  out_pix_t hsv_expected[$];
  out_pix_t hsv_want;

  int in_gap;
  int out_stall;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_grey = 0;
  int n_black = 0;
  int cycle_count = 0;
  logic calm;

  rgb_to_hsv_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pix   (in_pix),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pix  (out_pix)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one quarter of the time neither side idles
  assign calm = (cycle_count % 512) >= 384;

  // hue in units of 2**-HUE_BITS of a turn, exact integer form; grey and black give zero
  function automatic out_pix_t predict_hsv(in_pix_t p);
    int r, g, b, mx, mn, delta, num, span;
    out_pix_t res;
    r = p.red_in;
    g = p.green_in;
    b = p.blue_in;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    res = '0;
    if (delta != 0) begin
      span = 6 * delta;
      if (r == mx) num = g - b;
      else if (g == mx) num = 2 * delta + b - r;
      else num = 4 * delta + r - g;
      if (num < 0) num += span;
      res.hue_out = HUE_BITS'((num << HUE_BITS) / span);
    end
    if (mx != 0) res.saturation_out = SAT_BITS'((delta << SAT_FRAC_BITS) / mx);
    res.value_out = CHANNEL_BITS'(mx);
    res.alpha_out = p.alpha_in;
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int clip_chan(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic int extreme_or_any();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic add_pixel(int r, int g, int b, int a);
    in_pix_t p;
    p.red_in   = CHANNEL_BITS'(r);
    p.green_in = CHANNEL_BITS'(g);
    p.blue_in  = CHANNEL_BITS'(b);
    p.alpha_in = CHANNEL_BITS'(a);
    pixel_queue.push_back(p);
  endtask

  task automatic add_random_pixel();
    int kind, base, lo, a, r, g, b;
    kind = $urandom_range(0, 9);
    a = ($urandom_range(0, 9) == 0) ? extreme_or_any() : $urandom_range(0, 255);
    r = $urandom_range(0, 255);
    g = $urandom_range(0, 255);
    b = $urandom_range(0, 255);
    case (kind)
      4: begin
        g = r;
        b = r;
      end
      5: begin
        // two channels tied at the top, third below
        base = $urandom_range(1, 255);
        lo = $urandom_range(0, base - 1);
        case ($urandom_range(0, 2))
          0: begin r = base; g = base; b = lo; end
          1: begin g = base; b = base; r = lo; end
          default: begin r = base; b = base; g = lo; end
        endcase
      end
      6: begin
        base = $urandom_range(0, 255);
        r = clip_chan(base + $urandom_range(0, 4) - 2);
        g = clip_chan(base + $urandom_range(0, 4) - 2);
        b = clip_chan(base + $urandom_range(0, 4) - 2);
      end
      7: begin
        r = extreme_or_any();
        g = extreme_or_any();
        b = extreme_or_any();
      end
      8: begin
        r = $urandom_range(0, 3);
        g = $urandom_range(0, 3);
        b = $urandom_range(0, 3);
      end
      default: ;
    endcase
    add_pixel(r, g, b, a);
  endtask

  // input side: a transfer pushes its expected HSV, then the next pixel or a gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        hsv_expected.push_back(predict_hsv(in_pix));
        n_sent = n_sent + 1;
        if (in_pix.red_in == in_pix.green_in && in_pix.green_in == in_pix.blue_in) begin
          n_grey = n_grey + 1;
          if (in_pix.red_in == '0) n_black = n_black + 1;
        end
      end
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pixel_queue.size() > 0) begin
        in_pix <= pixel_queue.pop_front();
        in_valid <= 1'b1;
        in_gap <= calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: check each transfer, stall out_ready at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (hsv_expected.size() == 0) begin
          $error("result with no pixel pending: hue %0d sat %0d value %0d alpha %0d",
                 out_pix.hue_out, out_pix.saturation_out, out_pix.value_out,
                 out_pix.alpha_out);
          errors = errors + 1;
        end else begin
          hsv_want = hsv_expected.pop_front();
          n_checked = n_checked + 1;
          if (out_pix.hue_out !== hsv_want.hue_out) begin
            $error("hue_out: expected %0d, got %0d", hsv_want.hue_out, out_pix.hue_out);
            errors = errors + 1;
          end
          if (out_pix.saturation_out !== hsv_want.saturation_out) begin
            $error("saturation_out: expected %0d, got %0d",
                   hsv_want.saturation_out, out_pix.saturation_out);
            errors = errors + 1;
          end
          if (out_pix.value_out !== hsv_want.value_out) begin
            $error("value_out: expected %0d, got %0d", hsv_want.value_out, out_pix.value_out);
            errors = errors + 1;
          end
          if (out_pix.alpha_out !== hsv_want.alpha_out) begin
            $error("alpha_out: expected %0d, got %0d", hsv_want.alpha_out, out_pix.alpha_out);
            errors = errors + 1;
          end
        end
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        out_ready <= 1'b0;
        out_stall <= pick_gap();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout: %0d pixels sent, %0d results checked", n_sent, n_checked);
      $display("rgb_to_hsv_converter verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pix = '0;
    out_ready = 1'b0;

    // corners: black, white, grey, primaries, ties, hue wrap below red
    add_pixel(0, 0, 0, 0);
    add_pixel(255, 255, 255, 255);
    add_pixel(128, 128, 128, 77);
    add_pixel(255, 0, 0, 255);
    add_pixel(0, 255, 0, 0);
    add_pixel(0, 0, 255, 128);
    add_pixel(255, 255, 0, 1);
    add_pixel(0, 255, 255, 254);
    add_pixel(255, 0, 255, 0);
    add_pixel(255, 0, 1, 255);
    add_pixel(200, 10, 199, 33);
    add_pixel(1, 0, 0, 2);
    add_pixel(0, 1, 1, 3);
    add_pixel(255, 254, 254, 4);
    add_pixel(254, 255, 254, 5);
    add_pixel(254, 254, 255, 6);
    add_pixel(10, 20, 30, 7);
    add_pixel(30, 20, 10, 8);
    add_pixel(170, 85, 0, 9);
    add_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
    add_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
    add_pixel(1, 1, 1, 255);
    repeat (NUM_RANDOM) add_random_pixel();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pixel_queue.size() != 0 || in_valid) @(posedge clk);
    while (hsv_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d pixels (%0d grey, %0d black) incl. primaries, ties and hue wrap",
             n_sent, n_grey, n_black);
    $display("%0d results checked under random input gaps and output stalls", n_checked);
    if (errors == 0) begin
      $display("rgb_to_hsv_converter verification clean");
    end else begin
      $display("rgb_to_hsv_converter verification failed");
    end
    $finish;
  end

endmodule
